/* design/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants, codes and types for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int SYMBOLS      = 256;
    localparam int MAX_CODE_LEN = 16;
    localparam int CODE_BITS    = 16;
    localparam int LEN_BITS     = 5;
    localparam int BYTE_BITS    = 8;
    localparam int ACC_BITS     = 7;
    localparam int HELD_BITS    = 3;

    localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int ENTRY_W = LEN_BITS + CODE_BITS;
    localparam int VAL_W   = ACC_BITS + MAX_CODE_LEN;
    localparam int TOT_W   = $clog2(VAL_W + 1);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [SYM_W-1:0]   addr;
        logic [ENTRY_W-1:0] wr_data;
    } t_ram_req;

endpackage

/* design/hcbp_code_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_code_ram
// Code table: one entry per symbol, length and code word, registered read.
// ----------------------------------------------------------------------------
module hcbp_code_ram (
    input  logic                      i_clk,
    input  hcbp_pkg::t_ram_req        i_req,
    output logic [hcbp_pkg::ENTRY_W-1:0] o_rd_data
);
    import hcbp_pkg::*;

    logic [ENTRY_W-1:0] r_mem [SYMBOLS];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/hcbp_packer.sv */
// ----------------------------------------------------------------------------
// hcbp_packer
// Item sequencer, bit accumulator and output register. Drives the code table.
// ----------------------------------------------------------------------------
module hcbp_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_kind,
    input  logic [7:0]                     i_symbol,
    input  logic [hcbp_pkg::CODE_BITS-1:0] i_code_word,
    input  logic [hcbp_pkg::LEN_BITS-1:0]  i_code_length,
    output hcbp_pkg::t_ram_req             o_ram_req,
    input  logic [hcbp_pkg::ENTRY_W-1:0]   i_ram_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_packed_byte,
    output logic                           o_last
);
    import hcbp_pkg::*;

    t_state               r_state, n_state;
    logic [VAL_W-1:0]     r_value, n_value;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [ACC_BITS-1:0]  r_acc;
    logic [HELD_BITS-1:0] r_held;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 accept;
    logic                 sym_ok;
    logic                 out_free;
    logic                 out_load;
    logic [7:0]           out_byte;
    logic                 out_last;
    logic                 acc_commit;
    logic                 acc_clear;

    logic [LEN_BITS-1:0]  len_sat;
    logic [CODE_BITS:0]   len_mask;
    logic [LEN_BITS-1:0]  rd_len;
    logic [VAL_W-1:0]     emit_shift;
    logic [2*BYTE_BITS-1:0] flush_shift;
    logic [ACC_BITS:0]    keep_mask;

    assign out_free = !r_out_valid || !i_stall;
    assign sym_ok   = ({1'b0, i_symbol} < 9'(SYMBOLS));
    assign accept   = i_valid && !o_stall;

    assign len_sat  = (i_code_length > LEN_BITS'(MAX_CODE_LEN)) ?
                      LEN_BITS'(MAX_CODE_LEN) : i_code_length;
    assign len_mask = (CODE_BITS+1)'((CODE_BITS+1)'(1) << len_sat) - (CODE_BITS+1)'(1);

    assign rd_len      = i_ram_data[ENTRY_W-1:CODE_BITS];
    assign emit_shift  = r_value >> (r_total - TOT_W'(BYTE_BITS));
    assign flush_shift = (2*BYTE_BITS)'(r_acc) << (5'(BYTE_BITS) - 5'(r_held));
    assign keep_mask   = (ACC_BITS+1)'((ACC_BITS+1)'(1) << r_total[HELD_BITS-1:0])
                         - (ACC_BITS+1)'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_kind == KIND_ENCODE && sym_ok) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_total < TOT_W'(BYTE_BITS)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall           = 1'b1;
        o_ram_req.wr_en   = 1'b0;
        o_ram_req.rd_en   = 1'b0;
        o_ram_req.addr    = i_symbol[SYM_W-1:0];
        o_ram_req.wr_data = {len_sat, i_code_word & len_mask[CODE_BITS-1:0]};
        out_load          = 1'b0;
        out_byte          = emit_shift[7:0];
        out_last          = 1'b0;
        acc_commit        = 1'b0;
        acc_clear         = 1'b0;
        n_value           = r_value;
        n_total           = r_total;
        case (r_state)
            ST_IDLE: begin
                o_stall = (i_kind == KIND_FLUSH) && !out_free;
                if (accept) begin
                    case (i_kind)
                        KIND_LOAD: begin
                            o_ram_req.wr_en = sym_ok;
                        end
                        KIND_ENCODE: begin
                            o_ram_req.rd_en = sym_ok;
                        end
                        KIND_FLUSH: begin
                            out_load  = 1'b1;
                            out_byte  = flush_shift[7:0];
                            out_last  = 1'b1;
                            acc_clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_value = (VAL_W'(r_acc) << rd_len) | VAL_W'(i_ram_data[CODE_BITS-1:0]);
                n_total = TOT_W'(r_held) + TOT_W'(rd_len);
            end
            ST_EMIT: begin
                if (r_total >= TOT_W'(BYTE_BITS)) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_total  = r_total - TOT_W'(BYTE_BITS);
                    end
                end else begin
                    acc_commit = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_clear) begin
                r_acc  <= '0;
                r_held <= '0;
            end else if (acc_commit) begin
                r_acc  <= r_value[ACC_BITS-1:0] & keep_mask[ACC_BITS-1:0];
                r_held <= r_total[HELD_BITS-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_total <= n_total;
        if (out_load) begin
            r_out_byte <= out_byte;
            r_out_last <= out_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_last        = r_out_last;

endmodule

/* design/huffman_code_bit_packer_top.sv */
// A load writes its entry at acceptance; a flush beat shows in the cycle after
// acceptance; an encode reads the table, merges the code, then emits 0 to 2
// bytes. Loads go 1 per cycle while idle, flushes too if the output is free;
// encodes one at a time, set by the code table read and the output register,
// which sends one byte per cycle unless stalled. Reset clears the accumulator,
// bit count and output valid, not the code table: garbage until loaded.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Huffman encoder: code table lookup and MSB-first byte packing with flush.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_kind,
    input  logic [7:0]                     i_symbol,
    input  logic [hcbp_pkg::CODE_BITS-1:0] i_code_word,
    input  logic [hcbp_pkg::LEN_BITS-1:0]  i_code_length,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_packed_byte,
    output logic                           o_last
);
    import hcbp_pkg::*;

    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_data;

    hcbp_code_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_data)
    );

    hcbp_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .i_code_word   (i_code_word),
        .i_code_length (i_code_length),
        .o_ram_req     (ram_req),
        .i_ram_data    (ram_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_last        (o_last)
    );

endmodule

/* design/hcbp_checker.sv */
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks for the Huffman code bit packer.
// ----------------------------------------------------------------------------
module hcbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_kind,
    input logic [7:0] i_symbol,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_packed_byte,
    input logic       o_last
);
    import hcbp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_packed_byte) && $stable(o_last))
        else $error("stalled output beat changed");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == KIND_FLUSH |=> o_valid && o_last)
        else $error("flush did not produce a last beat");

    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == KIND_ENCODE && ({1'b0, i_symbol} < 9'(SYMBOLS))
        |=> o_stall)
        else $error("input taken during table read");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_kind        (i_kind),
    .i_symbol      (i_symbol),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_packed_byte (o_packed_byte),
    .o_last        (o_last)
);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Huffman code bit packer. A scoreboard keeps its own code
// table and byte accumulator and predicts every packed byte from the accepted
// beats. Directed beats cover the extremes and corner cases of loads, encodes
// and flushes. Random traffic follows: mostly encodes of loaded symbols mixed
// with table reloads, flushes and ignored kinds. Both handshake sides idle at
// random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import hcbp_pkg::*;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int IDLE_PCT       = 31;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_beat;

    class huff_byte_scoreboard;
        logic [LEN_BITS-1:0]  len_tbl  [SYMBOLS];
        logic [CODE_BITS-1:0] code_tbl [SYMBOLS];
        logic [ACC_BITS-1:0]  acc  = '0;
        logic [HELD_BITS-1:0] held = '0;
        t_byte_beat expected_bytes[$];
        int errors     = 0;
        int beats_seen = 0;
        int loads      = 0;
        int encodes    = 0;
        int flushes    = 0;
        int ignored    = 0;

        function void note_item(logic [1:0] kind, logic [7:0] sym,
                                logic [CODE_BITS-1:0] word, logic [LEN_BITS-1:0] len);
            logic [LEN_BITS-1:0] clen;
            logic [22:0]         value;
            logic [4:0]          total;
            case (kind)
                KIND_LOAD: begin
                    clen = (len > MAX_CODE_LEN) ? LEN_BITS'(MAX_CODE_LEN) : len;
                    len_tbl[sym]  = clen;
                    code_tbl[sym] = word & CODE_BITS'((32'd1 << clen) - 32'd1);
                    loads++;
                end
                KIND_ENCODE: begin
                    clen  = len_tbl[sym];
                    value = (23'(acc) << clen) | 23'(code_tbl[sym]);
                    total = 5'(held) + 5'(clen);
                    while (total >= 5'(BYTE_BITS)) begin
                        expected_bytes.push_back(
                            t_byte_beat'{8'(value >> (total - 5'(BYTE_BITS))), 1'b0});
                        total -= 5'(BYTE_BITS);
                    end
                    acc  = ACC_BITS'(value & ((23'd1 << total) - 23'd1));
                    held = HELD_BITS'(total);
                    encodes++;
                end
                KIND_FLUSH: begin
                    expected_bytes.push_back(
                        t_byte_beat'{8'({1'b0, acc} << (4'd8 - 4'(held))), 1'b1});
                    acc  = '0;
                    held = '0;
                    flushes++;
                end
                default: ignored++;
            endcase
        endfunction

        function void check_beat(logic [7:0] data, logic last);
            t_byte_beat want;
            beats_seen++;
            if (expected_bytes.size() == 0) begin
                errors++;
                $error("unexpected beat: packed_byte %02h last %0b", data, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data) begin
                errors++;
                $error("packed_byte: expected %02h, actual %02h", want.data, data);
            end
            if (last !== want.last) begin
                errors++;
                $error("last: expected %0b, actual %0b", want.last, last);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_kind;
    logic [7:0]           i_symbol;
    logic [CODE_BITS-1:0] i_code_word;
    logic [LEN_BITS-1:0]  i_code_length;
    logic                 o_valid;
    logic                 i_stall;
    logic [7:0]           o_packed_byte;
    logic                 o_last;

    huff_byte_scoreboard sb;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;
    int loaded_syms[$];
    bit is_loaded[SYMBOLS];

    huffman_code_bit_packer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .i_code_word   (i_code_word),
        .i_code_length (i_code_length),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_item(logic [1:0] kind, logic [7:0] sym,
                             logic [CODE_BITS-1:0] word, logic [LEN_BITS-1:0] len);
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_symbol      <= sym;
        i_code_word   <= word;
        i_code_length <= len;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(kind, sym, word, len);
        if (kind == KIND_LOAD && !is_loaded[sym]) begin
            is_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    task automatic send_load(logic [7:0] sym, logic [CODE_BITS-1:0] word,
                             logic [LEN_BITS-1:0] len);
        send_item(KIND_LOAD, sym, word, len);
    endtask

    task automatic send_encode(logic [7:0] sym);
        send_item(KIND_ENCODE, sym, CODE_BITS'($urandom), LEN_BITS'($urandom));
    endtask

    task automatic send_flush();
        send_item(KIND_FLUSH, 8'($urandom), CODE_BITS'($urandom), LEN_BITS'($urandom));
    endtask

    // receiver: random stall plus one long hold-off
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_beat(o_packed_byte, o_last);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !rx_quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("huffman_code_bit_packer_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int r;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = KIND_LOAD;
        i_symbol      = '0;
        i_code_word   = '0;
        i_code_length = '0;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_flush();
        send_load(8'd0,   16'hFFFF, 5'd0);
        send_load(8'd255, 16'hFFFF, 5'd16);
        send_load(8'd1,   16'hA5C3, 5'd31);
        send_load(8'd2,   16'h0001, 5'd1);
        send_load(8'd3,   16'hFFFA, 5'd3);
        send_load(8'd128, 16'h0001, 5'd17);
        send_encode(8'd0);
        send_encode(8'd255);
        send_encode(8'd2);
        send_encode(8'd1);
        send_encode(8'd3);
        send_item(KIND_NOP, 8'hFF, 16'hFFFF, 5'h1F);
        send_flush();
        repeat (8) send_encode(8'd2);
        send_flush();
        send_encode(8'd128);
        send_flush();

        hold_req <= 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            tx_quiet = (n >= 200 && n < 300);
            rx_quiet = (n >= 200 && n < 300);
            r = $urandom_range(99);
            if (r < 18) begin
                case ($urandom_range(9))
                    0:       send_load(8'($urandom), CODE_BITS'($urandom), 5'd0);
                    1:       send_load(8'($urandom), CODE_BITS'($urandom),
                                       LEN_BITS'($urandom_range(31, 17)));
                    default: send_load(8'($urandom), CODE_BITS'($urandom),
                                       LEN_BITS'($urandom_range(16, 1)));
                endcase
            end else if (r < 85) begin
                send_encode(8'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]));
            end else if (r < 96) begin
                send_flush();
            end else begin
                send_item(KIND_NOP, 8'($urandom), CODE_BITS'($urandom), LEN_BITS'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads, %0d encodes, %0d flushes, %0d ignored beats",
                 sb.loads, sb.encodes, sb.flushes, sb.ignored);
        $display("checked %0d packed bytes, with one %0d-cycle receiver hold-off",
                 sb.beats_seen, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("huffman_code_bit_packer_top: match");
        else
            $display("huffman_code_bit_packer_top: mismatch");
        $finish;
    end

endmodule
